FILE: design/sl1g_pkg.sv
package sl1g_pkg;

	// Field and register widths
	localparam int DataW     = 16;
	localparam int BetaW     = 15;
	localparam int InvBetaW  = 24;
	localparam int InvCountW = 25;
	localparam int SumW      = 48;
	localparam int CfgIdxW   = 2;

	// Shared multiplier operand and product widths
	localparam int MulAW = 30;
	localparam int MulBW = 25;
	localparam int ProdW = MulAW + MulBW;

	// Register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] REG_BETA      = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_INV_BETA  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_INV_COUNT = 2'd2;

	// Register reset values
	localparam logic [BetaW-1:0]     BETA_RST      = 15'd256;
	localparam logic [InvBetaW-1:0]  INV_BETA_RST  = 24'd65536;
	localparam logic [InvCountW-1:0] INV_COUNT_RST = 25'd16777216;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_TERM,
		ST_GRAW,
		ST_GRAD,
		ST_MHI,
		ST_MLO,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MUL_SQ,
		MUL_TERM,
		MUL_GRAW,
		MUL_GRAD,
		MUL_MHI,
		MUL_MLO
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     term_en;
		logic     acc_en;
		logic     grad_en;
		logic     mhi_en;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

FILE: design/sl1g_ctrl.sv
module sl1g_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  sl1g_pkg::dp_status_t status,
	output sl1g_pkg::dp_cmd_t    cmd
);
	import sl1g_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_next = ST_SQ;
				end
			end
			ST_SQ:   state_next = ST_TERM;
			ST_TERM: state_next = ST_GRAW;
			ST_GRAW: state_next = ST_GRAD;
			ST_GRAD: state_next = ST_MHI;
			ST_MHI:  state_next = ST_MLO;
			ST_MLO:  state_next = ST_OUT;
			ST_OUT: begin
				if (status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_SQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SQ;
			end
			ST_TERM: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_TERM;
			end
			ST_GRAW: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GRAW;
				cmd.term_en = 1'b1;
			end
			ST_GRAD: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GRAD;
				cmd.acc_en  = 1'b1;
			end
			ST_MHI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MHI;
				cmd.grad_en = 1'b1;
			end
			ST_MLO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MLO;
				cmd.mhi_en  = 1'b1;
			end
			ST_OUT: begin
				cmd.out_load = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result loaded while output register is occupied");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SQ))
		else $error("accepted item did not start the sequence");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !status.out_free) |=> (state_q == ST_OUT))
		else $error("sequencer left the output state while stalled");

endmodule

FILE: design/sl1g_datapath.sv
module sl1g_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sl1g_pkg::dp_cmd_t                   cmd,
	output sl1g_pkg::dp_status_t                status,
	input  logic [sl1g_pkg::BetaW-1:0]          beta,
	input  logic [sl1g_pkg::InvBetaW-1:0]       inv_beta,
	input  logic [sl1g_pkg::InvCountW-1:0]      inv_count,
	input  logic [2*sl1g_pkg::DataW-1:0]        s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sl1g_pkg::DataW+sl1g_pkg::SumW-1:0] m_tdata,
	output logic                                m_tlast
);
	import sl1g_pkg::*;

	// Difference and region decision, taken on the accept edge
	logic [16:0] diff;
	logic [16:0] abs_in;
	logic        quad_in;
	logic        neg_in;

	logic [16:0] a_q;
	logic        quad_q;
	logic        neg_q;
	logic        last_q;

	logic [MulAW-1:0] mul_a;
	logic [MulBW-1:0] mul_b;
	logic [ProdW-1:0] prod_q;

	logic [17:0] lin_diff;
	logic [28:0] term_q;
	logic [48:0] sum_next;
	logic [SumW-1:0] sum_q;

	logic [22:0] graw;
	logic [23:0] gmag;
	logic [DataW-1:0] grad_val;
	logic [DataW-1:0] grad_q;

	logic [48:0] mhi_q;
	logic [49:0] mean_sum;
	logic [SumW-1:0] mean_val;

	logic            out_valid_q;
	logic [DataW-1:0] out_grad_q;
	logic [SumW-1:0] out_mean_q;
	logic            out_last_q;

	assign diff    = {s_tdata[DataW-1], s_tdata[DataW-1:0]}
		- {s_tdata[2*DataW-1], s_tdata[2*DataW-1:DataW]};
	assign abs_in  = diff[16] ? (~diff + 17'd1) : diff;
	assign quad_in = abs_in < {2'b00, beta};
	// In the linear region a zero difference counts as negative.
	assign neg_in  = quad_in ? diff[16] : (diff[16] | (diff == 17'd0));

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			a_q    <= abs_in;
			quad_q <= quad_in;
			neg_q  <= neg_in;
			last_q <= s_tlast;
		end
	end

	assign graw = quad_q ? prod_q[38:16] : 23'd256;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MUL_SQ: begin
				mul_a = {13'd0, a_q};
				mul_b = {8'd0, a_q};
			end
			MUL_TERM: begin
				mul_a = prod_q[MulAW-1:0];
				mul_b = {1'b0, inv_beta};
			end
			MUL_GRAW: begin
				mul_a = {13'd0, a_q};
				mul_b = {1'b0, inv_beta};
			end
			MUL_GRAD: begin
				mul_a = {7'd0, graw};
				mul_b = inv_count;
			end
			MUL_MHI: begin
				mul_a = {6'd0, sum_q[47:24]};
				mul_b = inv_count;
			end
			MUL_MLO: begin
				mul_a = {6'd0, sum_q[23:0]};
				mul_b = inv_count;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
		end
	end

	// Linear term (2a - beta) / 2, truncated
	assign lin_diff = {a_q, 1'b0} - {3'd0, beta};

	always_ff @(posedge clk) begin
		if (cmd.term_en) begin
			term_q <= quad_q ? prod_q[53:25] : {12'd0, lin_diff[17:1]};
		end
	end

	assign sum_next = {1'b0, sum_q} + {20'd0, term_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.acc_en) begin
			sum_q <= sum_next[48] ? {SumW{1'b1}} : sum_next[SumW-1:0];
		end else if (cmd.out_load && last_q) begin
			sum_q <= '0;
		end
	end

	assign gmag = prod_q[47:24];

	always_comb begin
		if (neg_q) begin
			grad_val = (gmag >= 24'd32768) ? 16'h8000 : (~gmag[15:0] + 16'd1);
		end else begin
			grad_val = (gmag > 24'd32767) ? 16'h7fff : gmag[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.grad_en) begin
			grad_q <= grad_val;
		end
		if (cmd.mhi_en) begin
			mhi_q <= prod_q[48:0];
		end
	end

	// Mean = high partial + (low partial >> 24), saturated to 48 bits
	assign mean_sum = {1'b0, mhi_q} + {25'd0, prod_q[48:24]};
	assign mean_val = (mean_sum[49:48] != 2'b00) ? {SumW{1'b1}} : mean_sum[SumW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_grad_q <= grad_q;
			out_mean_q <= last_q ? mean_val : '0;
			out_last_q <= last_q;
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tdata         = {out_mean_q, out_grad_q};
	assign m_tlast         = out_last_q;

	a_mean_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[DataW+SumW-1:DataW] == '0))
		else $error("mean loss shown on a result that does not close a run");

	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && last_q) |=> (sum_q == '0))
		else $error("loss sum not cleared after the last item");

endmodule

FILE: design/smooth_l1_loss_gradient.sv
// Smooth L1 (Huber) loss gradient with running mean loss.
// An item steps through the states SQ, TERM, GRAW, GRAD, MHI, MLO and OUT, and its result
// enters the output register on leaving OUT. The next item is taken only then, since each
// item uses the single shared 30x25 multiplier six times in sequence; a stalled output holds
// the sequencer in OUT. Reset (arst_n low, asynchronous): registers return to beta 1.0,
// inv_beta 1.0, inv_count 1.0, the loss sum clears and the output register empties.
module smooth_l1_loss_gradient (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Input items
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [2*sl1g_pkg::DataW-1:0]           s_tdata, // [15:0] prediction, [31:16] target
	input  logic                                   s_tlast, // last_in
	// Result items
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [sl1g_pkg::DataW+sl1g_pkg::SumW-1:0] m_tdata, // [15:0] gradient, [63:16] mean_loss
	output logic                                   m_tlast, // last_out
	// Configuration writes
	input  logic                                   cfg_wr_en,
	input  logic [sl1g_pkg::CfgIdxW-1:0]           cfg_index,
	input  logic [sl1g_pkg::InvCountW-1:0]         cfg_data
);
	import sl1g_pkg::*;

	logic [BetaW-1:0]     beta_q;
	logic [InvBetaW-1:0]  inv_beta_q;
	logic [InvCountW-1:0] inv_count_q;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Configuration registers. Software keeps inv_beta and inv_count consistent
	// with beta and the element count; the hardware uses them as written.
	// A write to an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q      <= BETA_RST;
			inv_beta_q  <= INV_BETA_RST;
			inv_count_q <= INV_COUNT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BETA:      beta_q      <= cfg_data[BetaW-1:0];
				REG_INV_BETA:  inv_beta_q  <= cfg_data[InvBetaW-1:0];
				REG_INV_COUNT: inv_count_q <= cfg_data;
				default: begin
					beta_q <= beta_q;
				end
			endcase
		end
	end

	// The sequencer walks each item through the multiplier steps: square of
	// |d|, quadratic term, raw gradient, scaled gradient (with the accumulator
	// update), and the two halves of the mean-loss product.
	sl1g_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the item, the shared multiplier, the saturating
	// 48-bit loss accumulator and the output register. The output register
	// lets the next item be accepted while the previous result still waits.
	sl1g_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.beta      (beta_q),
		.inv_beta  (inv_beta_q),
		.inv_count (inv_count_q),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: verif/sl1g_checker.sv
`timescale 1ns / 1ps

// Watches the input, result and register write ports, predicts every result item
// and compares it with what the block delivers.
module sl1g_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	input  logic                                    s_tready,
	input  logic [2*sl1g_pkg::DataW-1:0]            s_tdata, // [15:0] prediction, [31:16] target
	input  logic                                    s_tlast, // last_in
	input  logic                                    m_tvalid,
	input  logic                                    m_tready,
	input  logic [sl1g_pkg::DataW+sl1g_pkg::SumW-1:0] m_tdata, // [15:0] gradient, [63:16] mean_loss
	input  logic                                    m_tlast, // last_out
	input  logic                                    cfg_wr_en,
	input  logic [sl1g_pkg::CfgIdxW-1:0]            cfg_index,
	input  logic [sl1g_pkg::InvCountW-1:0]          cfg_data,
	output int                                      fail_count,
	output int                                      pending
);
	import sl1g_pkg::*;

	localparam logic [SumW-1:0] SUM_MAX = '1;

	typedef struct packed {
		logic [DataW-1:0] gradient;
		logic [SumW-1:0]  mean_loss;
		logic             last;
	} loss_result_t;

	typedef struct packed {
		logic [DataW-1:0] gradient;
		logic [63:0]      term;
	} elem_eval_t;

	logic [BetaW-1:0]     beta_q;
	logic [InvBetaW-1:0]  inv_beta_q;
	logic [InvCountW-1:0] inv_count_q;
	logic [SumW-1:0]      loss_sum;
	loss_result_t         expected_q[$];

	// Gradient and loss term of one element under the given registers.
	function automatic elem_eval_t eval_element(input logic [DataW-1:0] pred,
			input logic [DataW-1:0] tgt, input logic [BetaW-1:0] b,
			input logic [InvBetaW-1:0] ib, input logic [InvCountW-1:0] ic);
		elem_eval_t         res;
		logic signed [DataW:0] diff;
		logic [63:0]        mag;
		logic [63:0]        graw;
		logic [63:0]        gmag;
		logic               neg;
		diff = $signed({pred[DataW-1], pred}) - $signed({tgt[DataW-1], tgt});
		mag = diff[DataW] ? 64'(-diff) : 64'(diff);
		if (mag < 64'(b)) begin
			res.term = (mag * mag * 64'(ib)) >> 25;
			graw = (mag * 64'(ib)) >> 16;
			neg = diff[DataW];
		end else begin
			// A zero difference lands here when beta is zero and counts as negative.
			res.term = ((mag << 1) - 64'(b)) >> 1;
			graw = 64'd256;
			neg = diff[DataW] || (diff == 0);
		end
		gmag = (graw * 64'(ic)) >> 24;
		if (neg)
			res.gradient = (gmag > 64'd32768) ? 16'h8000 : 16'(-gmag);
		else
			res.gradient = (gmag > 64'd32767) ? 16'h7fff : 16'(gmag);
		return res;
	endfunction

	// Sum times the Q1.24 reciprocal count, split so the product stays in 64 bits.
	function automatic logic [SumW-1:0] mean_of(input logic [SumW-1:0] sum,
			input logic [InvCountW-1:0] ic);
		logic [63:0] r;
		r = 64'(sum >> 24) * 64'(ic) + ((64'(sum[23:0]) * 64'(ic)) >> 24);
		return (r > 64'(SUM_MAX)) ? SUM_MAX : r[SumW-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		loss_result_t want;
		elem_eval_t   elem;
		logic [63:0]  total;
		if (!arst_n) begin
			beta_q = BETA_RST;
			inv_beta_q = INV_BETA_RST;
			inv_count_q = INV_COUNT_RST;
			loss_sum = '0;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("Result item with no expectation: %s %0d, %s %0d, %s %0b",
						"gradient", $signed(m_tdata[DataW-1:0]),
						"mean_loss", m_tdata[DataW+:SumW], "last_out", m_tlast);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (m_tdata[DataW-1:0] !== want.gradient) begin
						$error("gradient: expected %0d, actual %0d",
							$signed(want.gradient), $signed(m_tdata[DataW-1:0]));
						fail_count++;
					end
					if (m_tdata[DataW+:SumW] !== want.mean_loss) begin
						$error("mean_loss: expected %0d, actual %0d",
							want.mean_loss, m_tdata[DataW+:SumW]);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last_out: expected %0b, actual %0b", want.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				elem = eval_element(s_tdata[DataW-1:0], s_tdata[DataW+:DataW],
					beta_q, inv_beta_q, inv_count_q);
				total = 64'(loss_sum) + elem.term;
				loss_sum = (total > 64'(SUM_MAX)) ? SUM_MAX : total[SumW-1:0];
				want.gradient = elem.gradient;
				want.last = s_tlast;
				if (s_tlast) begin
					want.mean_loss = mean_of(loss_sum, inv_count_q);
					loss_sum = '0;
				end else begin
					want.mean_loss = '0;
				end
				expected_q.push_back(want);
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_BETA: begin
						beta_q = cfg_data[BetaW-1:0];
					end
					REG_INV_BETA: begin
						inv_beta_q = cfg_data[InvBetaW-1:0];
					end
					REG_INV_COUNT: begin
						inv_count_q = cfg_data;
					end
					default: begin
					end
				endcase
			end
			pending = expected_q.size();
		end
	end

endmodule

FILE: verif/tb_smooth_l1_loss_gradient.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the smooth L1 loss gradient block. The checker beside
// the block does all prediction and comparison; this module only drives the ports.
module tb_smooth_l1_loss_gradient;
	import sl1g_pkg::*;

	// Register index that selects no register; writes to it must be ignored.
	localparam logic [CfgIdxW-1:0] REG_NONE = 2'd3;
	// Generous bound for about 720 items in the slowest case of input gaps and result stalls.
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 88;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [2*DataW-1:0]    s_tdata; // [15:0] prediction, [31:16] target
	logic                  s_tlast; // last_in
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DataW+SumW-1:0] m_tdata; // [15:0] gradient, [63:16] mean_loss
	logic                  m_tlast; // last_out
	logic                  cfg_wr_en;
	logic [CfgIdxW-1:0]    cfg_index;
	logic [InvCountW-1:0]  cfg_data;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int items_sent = 0;
	int tensors_closed = 0;
	int settings_used = 0;
	// When set, neither side idles, so items go through back to back.
	bit quiet = 1'b0;

	always #6 clk = ~clk;

	smooth_l1_loss_gradient dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sl1g_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Watchdog. A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// One register write. It starts and ends on a rising edge; the enable drops
	// between two writes, so each edge sees one assignment.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [InvCountW-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Drops the input valid and waits until every predicted result has been taken.
	// Each item yields exactly one result, so an empty expectation queue means the
	// block holds no work and registers may be rewritten safely.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic set_config(input logic [BetaW-1:0] b, input logic [InvBetaW-1:0] ib,
			input logic [InvCountW-1:0] ic);
		wait_idle();
		write_reg(REG_BETA, InvCountW'(b));
		write_reg(REG_INV_BETA, InvCountW'(ib));
		write_reg(REG_INV_COUNT, ic);
		settings_used++;
	endtask

	// Sends one item. It is entered on a rising edge and returns on the edge at
	// which the item was accepted. Ready is looked at on the falling edge, where
	// it is settled and equal to what the next rising edge will see.
	task automatic send_item(input logic [DataW-1:0] pred, input logic [DataW-1:0] tgt,
			input logic last);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {tgt, pred};
		s_tlast <= last;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		items_sent++;
		if (last)
			tensors_closed++;
	endtask

	// Most items keep the difference within a little more than beta of zero so
	// both the quadratic and the linear region are hit often; the rest are fully
	// random so every input bit toggles.
	task automatic send_random(input logic [BetaW-1:0] b, input logic last);
		logic [DataW-1:0] pred;
		logic [DataW-1:0] tgt;
		int               spread;
		tgt = DataW'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			pred = DataW'($urandom);
		end else begin
			spread = int'(b) + 2;
			pred = tgt + DataW'($urandom_range(0, 2 * spread) - spread);
		end
		send_item(pred, tgt, last);
	endtask

	// Result side: stalls a random number of cycles before each item, or none in
	// quiet phases.
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
		end
	end

	initial begin
		int                   tensor_len;
		logic [BetaW-1:0]     b;
		logic [InvBetaW-1:0]  ib;
		logic [InvCountW-1:0] ic;
		logic                 last;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_BETA;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: beta 1.0. Zero difference, the widest differences both
		// ways, and both sides of the threshold in both signs.
		send_item(16'h0000, 16'h0000, 1'b0);
		send_item(16'h7fff, 16'h8000, 1'b0);
		send_item(16'h8000, 16'h7fff, 1'b0);
		send_item(16'd255, 16'h0000, 1'b0);
		send_item(16'd256, 16'h0000, 1'b0);
		send_item(16'h0000, 16'd256, 1'b0);
		send_item(16'h0000, 16'd255, 1'b0);
		send_item(16'hffff, 16'h0000, 1'b1);

		// Zero beta leaves no quadratic region, so a zero difference gives -1.0
		// scaled. The reciprocal of beta is zero and the count register is above
		// 1.0. A write to the unused index must change nothing.
		set_config(15'd0, 24'd0, 25'h1ffffff);
		write_reg(REG_NONE, 25'h1ffffff);
		send_item(16'h0000, 16'h0000, 1'b0);
		send_item(16'h0001, 16'h0000, 1'b0);
		send_item(16'h8000, 16'h8000, 1'b1);

		// Widest threshold with the largest reciprocal: the raw gradient is far
		// too large and must saturate in both directions.
		set_config(15'h7fff, 24'hffffff, INV_COUNT_RST);
		send_item(16'h7ffe, 16'h0000, 1'b0);
		send_item(16'h0000, 16'h7ffe, 1'b0);
		send_item(16'h7fff, 16'h0000, 1'b0);
		send_item(16'h0001, 16'h0000, 1'b1);

		// Smallest nonzero threshold and a zero count reciprocal: every gradient
		// and every mean collapses to zero.
		set_config(15'd1, 24'hffffff, 25'd0);
		send_item(16'h0000, 16'h0000, 1'b0);
		send_item(16'h1234, 16'h1233, 1'b1);

		// Random phases. Each picks a threshold with its matching reciprocal and a
		// tensor length with its reciprocal count, now and then arbitrary values
		// instead. Items come in whole tensors, with a few stray last marks.
		for (int p = 0; p < 8; p++) begin
			tensor_len = $urandom_range(1, 16);
			case ($urandom_range(0, 3))
				0: begin
					b = BetaW'($urandom_range(1, 32767));
				end
				1: begin
					b = BetaW'($urandom_range(1, 64));
				end
				default: begin
					b = BetaW'($urandom_range(64, 2048));
				end
			endcase
			if ($urandom_range(0, 4) == 0)
				ib = InvBetaW'($urandom);
			else
				ib = (b == 1) ? 24'hffffff : InvBetaW'((1 << 24) / int'(b));
			if ($urandom_range(0, 4) == 0)
				ic = InvCountW'($urandom_range(0, 25'h1ffffff));
			else
				ic = InvCountW'((1 << 24) / tensor_len);
			quiet = (p % 3 == 2);
			set_config(b, ib, ic);
			if (p == 3)
				write_reg(REG_NONE, InvCountW'($urandom));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 9) == 0)
					last = 1'($urandom_range(0, 1));
				else
					last = ((i % tensor_len) == tensor_len - 1);
				send_random(b, last);
			end
		end

		wait_idle();
		// Extra cycles so that any stray result after the last one is caught.
		repeat (20) @(posedge clk);

		$display("Drove %0d items under %0d register settings, %0d of them ending a tensor.",
			items_sent, settings_used + 1, tensors_closed);
		$display("Gaps and stalls of 0 to 9 cycles on both sides, with some phases at full rate.");
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
design/sl1g_pkg.sv
design/sl1g_ctrl.sv
design/sl1g_datapath.sv
design/smooth_l1_loss_gradient.sv
verif/sl1g_checker.sv
verif/tb_smooth_l1_loss_gradient.sv
